### design/hdlc_byte_stuff_framer_unit_assert.svh
// Assertion macros for the HDLC byte-stuffing framer.
// Included by the top level; no other dependencies.
`ifndef HDLC_BYTE_STUFF_FRAMER_UNIT_ASSERT_SVH
`define HDLC_BYTE_STUFF_FRAMER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define HBSF_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("%m: same-cycle implication violated");
`define HBSF_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("%m: next-cycle implication violated");
`else
`define HBSF_ASSERT_IMP(lbl, clk, rst, a, b)
`define HBSF_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

### design/hdlcbs_pkg.sv
// Shared types, constants and CRC function for the HDLC byte-stuffing framer.
// No dependencies.
package hdlcbs_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;   // 7D -> 5D, 7E -> 5E
   localparam logic [15:0] POLY_REFL = 16'h8408;
   localparam logic [15:0] POLY_NORM = 16'h1021;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register indexes
   localparam logic [1:0] REG_STUFF_ENABLE  = 2'd0;
   localparam logic [1:0] REG_CRC_INIT      = 2'd1;
   localparam logic [1:0] REG_CRC_XOR_OUT   = 2'd2;
   localparam logic [1:0] REG_CRC_REFLECTED = 2'd3;

   typedef struct packed {
      logic        stuff_enable;
      logic [15:0] crc_init;
      logic [15:0] crc_xor_out;
      logic        crc_reflected;
   } cfg_type;

   // One classified request, ready for output sequencing
   typedef struct packed {
      logic        open;
      logic        has_data;
      logic        last;
      logic [7:0]  data;
      logic [15:0] fcs;
   } entry_type;

   typedef struct packed {
      logic push;
      logic in_frame;
   } front_status_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc_i,
                                              input logic [7:0] b,
                                              input logic reflected);
      logic [15:0] c;
      c = crc_i;
      if (reflected) begin
         c = c ^ {8'h00, b};
         for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ POLY_REFL) : (c >> 1);
         end
      end else begin
         c = c ^ {b, 8'h00};
         for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ POLY_NORM) : (c << 1);
         end
      end
      return c;
   endfunction

endpackage

### design/hdlc_byte_stuff_framer_unit.sv
// HDLC byte-stuffing framer with CRC-16 FCS; front end, entry queue, back end.
// Requests pass through the entry queue and the back-end sequencer to a registered response.
// One response byte per cycle from the sequencer unless rsp_tready stalls it; a request
// with bytes gives 1 to 8 bytes (flag, data, escapes, FCS, flag), an idle one none.
// Reset (synchronous, active high) closes any frame, empties the queue and
// restores register defaults.
`include "hdlc_byte_stuff_framer_unit_assert.svh"
module hdlc_byte_stuff_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_data
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] frame_end
   output logic        rsp_tlast,   // run_last
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   import hdlcbs_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   entry_type        push_entry, q_head;
   front_status_type front_status;
   logic             q_full, q_not_empty, q_pop;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_STUFF_ENABLE:  cfg_in.stuff_enable  = csr_wr_data[0];
            REG_CRC_INIT:      cfg_in.crc_init      = csr_wr_data;
            REG_CRC_XOR_OUT:   cfg_in.crc_xor_out   = csr_wr_data;
            REG_CRC_REFLECTED: cfg_in.crc_reflected = csr_wr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stuff_enable  <= 1'b1;
         cfg_ff.crc_init      <= 16'hFFFF;
         cfg_ff.crc_xor_out   <= 16'hFFFF;
         cfg_ff.crc_reflected <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hdlcbs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_tvalid),
      .req_data     (req_tdata),
      .req_has_data (req_tuser),
      .req_last     (req_tlast),
      .q_full       (q_full),
      .req_ready    (req_tready),
      .q_entry      (push_entry),
      .status       (front_status)
   );

   hdlcbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_status.push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   hdlcbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_head        (q_head),
      .q_not_empty   (q_not_empty),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_byte      (rsp_tdata),
      .rsp_run_last  (rsp_tlast),
      .rsp_frame_end (rsp_tuser)
   );

   // closing flag ends the run and is the flag byte
   `HBSF_ASSERT_IMP(a_end_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `HBSF_ASSERT_IMP(a_end_is_flag, clock, reset, rsp_tvalid && rsp_tuser,
                    rsp_tdata == FLAG_BYTE)
   // queue never takes an entry when full
   `HBSF_ASSERT_IMP(a_no_overflow, clock, reset, front_status.push, !q_full)
   // a closing request leaves the frame closed
   `HBSF_ASSERT_NXT(a_close_frame, clock, reset,
                    front_status.push && req_tlast, !front_status.in_frame)

endmodule

### design/hdlcbs_front.sv
// Front end: accepts requests, tracks frame state and running CRC, and
// pushes classified entries into the queue. Depends on hdlcbs_pkg.
module hdlcbs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  hdlcbs_pkg::cfg_type           cfg,
   input  logic                          req_valid,
   input  logic [7:0]                    req_data,
   input  logic                          req_has_data,
   input  logic                          req_last,
   input  logic                          q_full,
   output logic                          req_ready,
   output hdlcbs_pkg::entry_type         q_entry,
   output hdlcbs_pkg::front_status_type  status
);
   import hdlcbs_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_start;
   logic [15:0] crc_new;
   logic        push;

   assign req_ready = !q_full;
   // idle requests are taken and dropped
   assign push = req_valid && req_ready && (req_has_data || req_last);

   // fold payload byte into the CRC, restarting at frame open
   always_comb begin
      crc_start = in_frame_ff ? crc_ff : cfg.crc_init;
      crc_new   = req_has_data ? crc_update(crc_start, req_data, cfg.crc_reflected)
                               : crc_start;
      q_entry.open     = !in_frame_ff;
      q_entry.has_data = req_has_data;
      q_entry.last     = req_last;
      q_entry.data     = req_data;
      q_entry.fcs      = crc_new ^ cfg.crc_xor_out;
      in_frame_in      = in_frame_ff;
      crc_in           = crc_ff;
      if (push) begin
         in_frame_in = !req_last;
         crc_in      = crc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
      crc_ff <= crc_in;
   end

   assign status.push     = push;
   assign status.in_frame = in_frame_ff;

endmodule

### design/hdlcbs_queue.sv
// Short FIFO of classified entries between front and back end.
// Depends on hdlcbs_pkg.
module hdlcbs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hdlcbs_pkg::entry_type  push_entry,
   input  logic                   pop,
   output hdlcbs_pkg::entry_type  head,
   output logic                   not_empty,
   output logic                   full
);
   import hdlcbs_pkg::*;

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/hdlcbs_back.sv
// Back end: walks each queued entry through the phases it needs (flag, payload,
// FCS, closing flag), escapes bytes, and drives the registered response. Depends on hdlcbs_pkg.
module hdlcbs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  hdlcbs_pkg::cfg_type    cfg,
   input  hdlcbs_pkg::entry_type  q_head,
   input  logic                   q_not_empty,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_frame_end
);
   import hdlcbs_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_OPEN, PH_DATA, PH_FCS_LO, PH_FCS_HI, PH_CLOSE
   } phase_type;

   phase_type   phase_ff, phase_in, phase_next, phase_start;
   entry_type   cur_ff, cur_in;
   logic        esc_ff, esc_in;
   logic [7:0]  esc_val_ff, esc_val_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        end_ff, end_in;

   logic [7:0]  value;
   logic [7:0]  out_b;
   logic        set_esc;
   logic        finish;
   logic        produce;

   // phase that follows the current one for this entry
   always_comb begin
      case (phase_ff)
         PH_OPEN:   phase_next = cur_ff.has_data ? PH_DATA : PH_FCS_LO;
         PH_DATA:   phase_next = cur_ff.last ? PH_FCS_LO : PH_IDLE;
         PH_FCS_LO: phase_next = PH_FCS_HI;
         PH_FCS_HI: phase_next = PH_CLOSE;
         default:   phase_next = PH_IDLE;
      endcase
      if (q_head.open) begin
         phase_start = PH_OPEN;
      end else if (q_head.has_data) begin
         phase_start = PH_DATA;
      end else begin
         phase_start = PH_FCS_LO;
      end
   end

   // pick the byte for this phase and escape it if needed
   always_comb begin
      case (phase_ff)
         PH_DATA:   value = cur_ff.data;
         PH_FCS_LO: value = cur_ff.fcs[7:0];
         default:   value = cur_ff.fcs[15:8];
      endcase
      set_esc = 1'b0;
      if (esc_ff) begin
         out_b = esc_val_ff;
      end else if (phase_ff inside {PH_OPEN, PH_CLOSE}) begin
         out_b = FLAG_BYTE;
      end else if (cfg.stuff_enable && (value inside {ESC_BYTE, FLAG_BYTE})) begin
         out_b   = ESC_BYTE;
         set_esc = 1'b1;
      end else begin
         out_b = value;
      end
      finish  = !set_esc && (phase_next == PH_IDLE);
      produce = (phase_ff != PH_IDLE) && (!valid_ff || rsp_ready);
      q_pop   = q_not_empty && ((phase_ff == PH_IDLE) || (produce && finish));
   end

   // sequencer and output register next values
   always_comb begin
      phase_in   = phase_ff;
      cur_in     = cur_ff;
      esc_in     = esc_ff;
      esc_val_in = esc_val_ff;
      valid_in   = rsp_ready ? 1'b0 : valid_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      end_in     = end_ff;
      if (produce) begin
         valid_in = 1'b1;
         byte_in  = out_b;
         last_in  = finish;
         end_in   = (phase_ff == PH_CLOSE) && !esc_ff;
         if (set_esc) begin
            esc_in     = 1'b1;
            esc_val_in = value ^ ESC_XOR;
         end else begin
            esc_in   = 1'b0;
            phase_in = phase_next;
         end
      end
      if (q_pop) begin
         cur_in   = q_head;
         phase_in = phase_start;
         esc_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         esc_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         valid_ff <= valid_in;
      end
      cur_ff     <= cur_in;
      esc_val_ff <= esc_val_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      end_ff     <= end_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_byte      = byte_ff;
   assign rsp_run_last  = last_ff;
   assign rsp_frame_end = end_ff;

endmodule
